@@ hdl/open_address_hash_table_core_defines.svh @@
// Assertion macros shared by the hash table core modules.
// Included by the controller and the datapath; depends on nothing else.
`ifndef OPEN_ADDRESS_HASH_TABLE_CORE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_CORE_DEFINES_SVH
`ifndef SYNTH
`define OAHT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hash table core assertion failed");
`define OAHT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash table core implication failed");
`else
`define OAHT_ASSERT(lbl, clk, rst, prop)
`define OAHT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/oaht_pkg.sv @@
// Shared types and constants of the hash table core.
// Used by oaht_ctrl, oaht_dp and open_address_hash_table_core; no dependencies.
package oaht_pkg;

   localparam int unsigned SLOTS_DEFAULT = 64;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned KEY_W = 32;
   localparam int unsigned HASH_W = 32;
   localparam int unsigned VAL_W = 64;
   localparam int unsigned MAX_W = 6;
   localparam int unsigned USED_W = 7;
   localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 6'd48;

   localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_LIVE = 2'd1;
   localparam logic [1:0] ST_TOMB = 2'd2;

   typedef struct packed {
      logic load;
      logic red_step;
      logic advance;
      logic eval;
      logic clear_step;
      logic commit;
   } oaht_cmd_type;

   typedef struct packed {
      logic red_done;
      logic clear_last;
      logic stop;
   } oaht_sts_type;

endpackage

@@ hdl/oaht_ctrl.sv @@
// Controller state machine of the hash table core: clearing pass, probe sequencing
// and the response valid flag. Depends on oaht_pkg and the defines header.
`include "open_address_hash_table_core_defines.svh"

module oaht_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  oaht_pkg::oaht_sts_type sts,
   output oaht_pkg::oaht_cmd_type cmd
);

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      HASH,
      PROBE,
      COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = HASH;
            end
         end
         HASH: begin
            if (sts.red_done) begin
               cmd.advance = 1'b1;
               state_in = PROBE;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         PROBE: begin
            cmd.eval = 1'b1;
            if (sts.stop) begin
               state_in = COMMIT;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `OAHT_ASSERT_IMPL(a_accept_to_hash, clock, reset, req_valid && req_ready, ##1 state_ff == HASH)
   `OAHT_ASSERT_IMPL(a_commit_out_free, clock, reset, cmd.commit, !rsp_valid_ff || rsp_ready)
   `OAHT_ASSERT_IMPL(a_no_accept_clear, clock, reset, state_ff == CLEAR, !req_ready)
   `OAHT_ASSERT(a_one_action, clock, reset, $onehot0({cmd.load, cmd.red_step, cmd.eval, cmd.clear_step, cmd.commit}))

endmodule

@@ hdl/oaht_dp.sv @@
// Datapath of the hash table core: slot memories, start slot reduction, probe
// bookkeeping, used count and response registers. Depends on oaht_pkg and the defines header.
`include "open_address_hash_table_core_defines.svh"

module oaht_dp #(
   parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [oaht_pkg::CMD_W-1:0]    req_cmd,
   input  logic [oaht_pkg::KEY_W-1:0]    req_key,
   input  logic [oaht_pkg::HASH_W-1:0]   req_key_hash,
   input  logic [oaht_pkg::VAL_W-1:0]    req_new_value,
   input  logic                          csr_wr_en,
   input  logic [oaht_pkg::MAX_W-1:0]    csr_wr_data,
   input  oaht_pkg::oaht_cmd_type        cmd,
   output oaht_pkg::oaht_sts_type        sts,
   output logic                          rsp_hit,
   output logic                          rsp_table_full,
   output logic [oaht_pkg::VAL_W-1:0]    rsp_value_out
);

   localparam int unsigned IdxW = $clog2(SLOTS);
   localparam logic IsPow2 = ((SLOTS & (SLOTS - 1)) == 0);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
   localparam int unsigned RedBits = 4;
   localparam int unsigned RedSteps = oaht_pkg::HASH_W / RedBits;
   localparam int unsigned RedCntW = $clog2(RedSteps + 1);

   logic [oaht_pkg::KEY_W-1:0] key_mem [SLOTS];
   logic [oaht_pkg::VAL_W-1:0] val_mem [SLOTS];
   logic [1:0]                 st_mem [SLOTS];

   logic [oaht_pkg::KEY_W-1:0]  key_rd_ff;
   logic [oaht_pkg::VAL_W-1:0]  val_rd_ff;
   logic [1:0]                  st_rd_ff;

   logic [oaht_pkg::CMD_W-1:0]  cmd_ff;
   logic [oaht_pkg::KEY_W-1:0]  key_ff;
   logic [oaht_pkg::HASH_W-1:0] hash_ff;
   logic [oaht_pkg::VAL_W-1:0]  val_ff;
   logic [IdxW-1:0]             addr_ff;
   logic [IdxW-1:0]             rd_addr_ff;
   logic [IdxW-1:0]             cnt_ff;
   logic [RedCntW-1:0]          red_cnt_ff;
   logic                        match_ff;
   logic                        empty_ff;
   logic                        tomb_seen_ff;
   logic [IdxW-1:0]             stop_idx_ff;
   logic [IdxW-1:0]             tomb_idx_ff;
   logic [oaht_pkg::VAL_W-1:0]  val_hit_ff;
   logic [oaht_pkg::USED_W-1:0] used_ff, used_in;
   logic [oaht_pkg::MAX_W-1:0]  max_ff;
   logic                        hit_ff, hit_in;
   logic                        full_ff, full_in;
   logic [oaht_pkg::VAL_W-1:0]  vout_ff, vout_in;

   logic [IdxW-1:0] next_idx;
   logic            slot_empty;
   logic            slot_tomb;
   logic            slot_match;
   logic            new_ok;
   logic            key_we;
   logic            val_we;
   logic            st_we;
   logic [IdxW-1:0] wr_idx;
   logic [1:0]      wr_st;

   function automatic logic [IdxW-1:0] red_step(input logic [IdxW-1:0] r,
                                                input logic [RedBits-1:0] b);
      logic [IdxW:0] t;
      t = {1'b0, r};
      for (int i = 0; i < RedBits; i++) begin
         t = {t[IdxW-1:0], b[RedBits-1-i]};
         if (t >= (IdxW+1)'(SLOTS)) begin
            t = t - (IdxW+1)'(SLOTS);
         end
      end
      return t[IdxW-1:0];
   endfunction

   assign next_idx = (addr_ff == LastIdx) ? '0 : addr_ff + 1'b1;
   assign slot_empty = (st_rd_ff == oaht_pkg::ST_EMPTY);
   assign slot_tomb = (st_rd_ff == oaht_pkg::ST_TOMB);
   assign slot_match = (st_rd_ff == oaht_pkg::ST_LIVE) && (key_rd_ff == key_ff);

   assign sts.stop = slot_empty || slot_match || (cnt_ff == LastIdx);
   assign sts.red_done = IsPow2 || (red_cnt_ff == RedCntW'(RedSteps));
   assign sts.clear_last = (addr_ff == LastIdx);

   assign new_ok = empty_ff && ((used_ff + 1'b1) <= {1'b0, max_ff});

   always_comb begin
      key_we = 1'b0;
      val_we = 1'b0;
      st_we = 1'b0;
      wr_idx = stop_idx_ff;
      wr_st = oaht_pkg::ST_LIVE;
      used_in = used_ff;
      hit_in = 1'b0;
      full_in = 1'b0;
      vout_in = '0;
      if (cmd.clear_step) begin
         st_we = 1'b1;
         wr_idx = addr_ff;
         wr_st = oaht_pkg::ST_EMPTY;
      end else if (cmd.commit) begin
         priority if (cmd_ff == oaht_pkg::CMD_GET) begin
            hit_in = match_ff;
            vout_in = match_ff ? val_hit_ff : '0;
         end else if (cmd_ff == oaht_pkg::CMD_SET) begin
            priority if (match_ff) begin
               val_we = 1'b1;
            end else if (tomb_seen_ff) begin
               key_we = 1'b1;
               val_we = 1'b1;
               st_we = 1'b1;
               wr_idx = tomb_idx_ff;
               hit_in = 1'b1;
            end else if (new_ok) begin
               key_we = 1'b1;
               val_we = 1'b1;
               st_we = 1'b1;
               used_in = used_ff + 1'b1;
               hit_in = 1'b1;
            end else begin
               full_in = 1'b1;
            end
         end else if (cmd_ff == oaht_pkg::CMD_DEL) begin
            if (match_ff) begin
               st_we = 1'b1;
               wr_st = oaht_pkg::ST_TOMB;
               hit_in = 1'b1;
            end
         end else begin
            hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[addr_ff];
      val_rd_ff <= val_mem[addr_ff];
      st_rd_ff <= st_mem[addr_ff];
      if (key_we) begin
         key_mem[wr_idx] <= key_ff;
      end
      if (val_we) begin
         val_mem[wr_idx] <= val_ff;
      end
      if (st_we) begin
         st_mem[wr_idx] <= wr_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         used_ff <= '0;
         max_ff <= oaht_pkg::MAX_ENTRIES_RESET;
      end else begin
         used_ff <= used_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         priority if (cmd.load) begin
            addr_ff <= IsPow2 ? req_key_hash[IdxW-1:0] : '0;
         end else if (cmd.red_step) begin
            addr_ff <= red_step(addr_ff, hash_ff[oaht_pkg::HASH_W-1 -: RedBits]);
         end else if (cmd.advance || cmd.clear_step) begin
            addr_ff <= next_idx;
         end else begin
            addr_ff <= addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         hash_ff <= req_key_hash;
         val_ff <= req_new_value;
         red_cnt_ff <= '0;
         cnt_ff <= '0;
         match_ff <= 1'b0;
         empty_ff <= 1'b0;
         tomb_seen_ff <= 1'b0;
      end
      if (cmd.red_step) begin
         hash_ff <= hash_ff << RedBits;
         red_cnt_ff <= red_cnt_ff + 1'b1;
      end
      if (cmd.advance) begin
         rd_addr_ff <= addr_ff;
      end
      if (cmd.eval) begin
         cnt_ff <= cnt_ff + 1'b1;
         stop_idx_ff <= rd_addr_ff;
         if (slot_tomb && !tomb_seen_ff) begin
            tomb_seen_ff <= 1'b1;
            tomb_idx_ff <= rd_addr_ff;
         end
         if (slot_match) begin
            match_ff <= 1'b1;
            val_hit_ff <= val_rd_ff;
         end
         if (slot_empty) begin
            empty_ff <= 1'b1;
         end
      end
      if (cmd.commit) begin
         hit_ff <= hit_in;
         full_ff <= full_in;
         vout_ff <= vout_in;
      end
   end

   assign rsp_hit = hit_ff;
   assign rsp_table_full = full_ff;
   assign rsp_value_out = vout_ff;

   `OAHT_ASSERT_IMPL(a_hit_excl_full, clock, reset, cmd.commit, !(hit_in && full_in))
   `OAHT_ASSERT_IMPL(a_used_step, clock, reset, used_ff != used_in, cmd.commit && new_ok && (cmd_ff == oaht_pkg::CMD_SET))

endmodule

@@ hdl/open_address_hash_table_core.sv @@
// Linear probing key/value table with tombstones; one response per request. Each request
// probes from 1 to SLOTS slots, and each memory read port delivers one slot per cycle. The
// next request can be taken in the cycle after the response is committed. When SLOTS is
// not a power of two, the start slot is reduced modulo SLOTS four hash bits a cycle. After
// reset a clearing pass marks every slot empty, and no request is accepted during it. A new
// request is taken while the last response waits.
// Built from oaht_ctrl and oaht_dp; depends on oaht_pkg.
module open_address_hash_table_core #(
   parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [oaht_pkg::CMD_W-1:0]    req_cmd,
   input  logic [oaht_pkg::KEY_W-1:0]    req_key,
   input  logic [oaht_pkg::HASH_W-1:0]   req_key_hash,
   input  logic [oaht_pkg::VAL_W-1:0]    req_new_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_table_full,
   output logic [oaht_pkg::VAL_W-1:0]    rsp_value_out,
   input  logic                          csr_wr_en,
   input  logic [oaht_pkg::MAX_W-1:0]    csr_wr_data
);

   oaht_pkg::oaht_cmd_type cmd;
   oaht_pkg::oaht_sts_type sts;

   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   oaht_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_key_hash   (req_key_hash),
      .req_new_value  (req_new_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_hit        (rsp_hit),
      .rsp_table_full (rsp_table_full),
      .rsp_value_out  (rsp_value_out)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for open_address_hash_table_core: get, set and delete requests
// are checked against a table model held in a small scoreboard class.
// Depends on oaht_pkg and the core RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = oaht_pkg::SLOTS_DEFAULT;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_REQUESTS = 125;
   localparam int POOL_KEYS = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = TABLE_SLOTS + 16;
   localparam int HOLD_CYCLES = 300;
   localparam logic [oaht_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [oaht_pkg::MAX_W-1:0] PHASE_LIMIT [RANDOM_PHASES] =
      '{6'd5, 6'd0, 6'd20, 6'd37, 6'd63, 6'd48};

   typedef struct packed {
      logic                       hit;
      logic                       full;
      logic [oaht_pkg::VAL_W-1:0] value;
   } lookup_result_type;

   class table_scoreboard;
      logic [oaht_pkg::KEY_W-1:0] slot_key [TABLE_SLOTS];
      logic [oaht_pkg::VAL_W-1:0] slot_value [TABLE_SLOTS];
      logic [1:0]                 slot_status [TABLE_SLOTS];
      int unsigned                used_count;
      logic [oaht_pkg::MAX_W-1:0] entry_limit;
      lookup_result_type          results_due [$];
      int                         errors;
      int                         requests;
      int                         hits;
      int                         refusals;

      function new();
         foreach (slot_status[i]) slot_status[i] = oaht_pkg::ST_EMPTY;
         used_count = 0;
         entry_limit = oaht_pkg::MAX_ENTRIES_RESET;
         errors = 0;
         requests = 0;
         hits = 0;
         refusals = 0;
      endfunction

      function void set_limit(logic [oaht_pkg::MAX_W-1:0] limit);
         entry_limit = limit;
      endfunction

      function int outstanding();
         return results_due.size();
      endfunction

      function void note_request(logic [oaht_pkg::CMD_W-1:0] cmd,
                                 logic [oaht_pkg::KEY_W-1:0] key,
                                 logic [oaht_pkg::HASH_W-1:0] key_hash,
                                 logic [oaht_pkg::VAL_W-1:0] new_value);
         int slot;
         int n;
         int found_slot;
         int tomb_slot;
         int empty_slot;
         bit stop;
         lookup_result_type res;
         res = '0;
         found_slot = -1;
         tomb_slot = -1;
         empty_slot = -1;
         stop = 1'b0;
         slot = int'(key_hash % TABLE_SLOTS);
         if (cmd == oaht_pkg::CMD_GET || cmd == oaht_pkg::CMD_SET ||
             cmd == oaht_pkg::CMD_DEL) begin
            for (n = 0; n < TABLE_SLOTS && !stop; n++) begin
               if (slot_status[slot] == oaht_pkg::ST_EMPTY) begin
                  empty_slot = slot;
                  stop = 1'b1;
               end else if (slot_status[slot] == oaht_pkg::ST_TOMB) begin
                  if (tomb_slot < 0) tomb_slot = slot;
               end else if (slot_key[slot] == key) begin
                  found_slot = slot;
                  stop = 1'b1;
               end
               if (!stop) slot = (slot + 1) % TABLE_SLOTS;
            end
         end
         case (cmd)
            oaht_pkg::CMD_GET: begin
               if (found_slot >= 0) begin
                  res.hit = 1'b1;
                  res.value = slot_value[found_slot];
               end
            end
            oaht_pkg::CMD_SET: begin
               if (found_slot >= 0) begin
                  slot_value[found_slot] = new_value;
               end else if (tomb_slot >= 0) begin
                  slot_status[tomb_slot] = oaht_pkg::ST_LIVE;
                  slot_key[tomb_slot] = key;
                  slot_value[tomb_slot] = new_value;
                  res.hit = 1'b1;
               end else if (empty_slot >= 0 && used_count + 1 <= entry_limit) begin
                  slot_status[empty_slot] = oaht_pkg::ST_LIVE;
                  slot_key[empty_slot] = key;
                  slot_value[empty_slot] = new_value;
                  used_count++;
                  res.hit = 1'b1;
               end else begin
                  res.full = 1'b1;
               end
            end
            oaht_pkg::CMD_DEL: begin
               if (found_slot >= 0) begin
                  slot_status[found_slot] = oaht_pkg::ST_TOMB;
                  res.hit = 1'b1;
               end
            end
            default: begin
            end
         endcase
         requests++;
         hits += int'(res.hit);
         refusals += int'(res.full);
         results_due.push_back(res);
      endfunction

      function void check_response(logic hit, logic full, logic [oaht_pkg::VAL_W-1:0] value);
         lookup_result_type due;
         if (results_due.size() == 0) begin
            $error("response arrived with no request outstanding");
            errors++;
            return;
         end
         due = results_due.pop_front();
         if (hit !== due.hit) begin
            $error("hit: expected %0d, got %0d", due.hit, hit);
            errors++;
         end
         if (full !== due.full) begin
            $error("table_full: expected %0d, got %0d", due.full, full);
            errors++;
         end
         if (value !== due.value) begin
            $error("value_out: expected %h, got %h", due.value, value);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [oaht_pkg::CMD_W-1:0]    req_cmd = '0;
   logic [oaht_pkg::KEY_W-1:0]    req_key = '0;
   logic [oaht_pkg::HASH_W-1:0]   req_key_hash = '0;
   logic [oaht_pkg::VAL_W-1:0]    req_new_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_hit;
   logic                          rsp_table_full;
   logic [oaht_pkg::VAL_W-1:0]    rsp_value_out;
   logic                          csr_wr_en = 1'b0;
   logic [oaht_pkg::MAX_W-1:0]    csr_wr_data = '0;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_request = 0;
   int hold_done = 0;
   int cycle_count = 0;

   table_scoreboard sb = new();

   open_address_hash_table_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_key_hash   (req_key_hash),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_table_full (rsp_table_full),
      .rsp_value_out  (rsp_value_out),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver holds off for a long stretch once the main sequence asks for it.
   always @(negedge clock) begin
      if (hold_done < hold_request) begin
         rsp_ready <= 1'b0;
         hold_done++;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         sb.check_response(rsp_hit, rsp_table_full, rsp_value_out);
      end
   end

   task automatic send_request(input logic [oaht_pkg::CMD_W-1:0] cmd,
                               input logic [oaht_pkg::KEY_W-1:0] key,
                               input logic [oaht_pkg::HASH_W-1:0] key_hash,
                               input logic [oaht_pkg::VAL_W-1:0] new_value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_key <= key;
      req_key_hash <= key_hash;
      req_new_value <= new_value;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(cmd, key, key_hash, new_value);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      end_burst();
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [oaht_pkg::MAX_W-1:0] limit);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(limit);
   endtask

   // Keys of one phase share a narrow window of start slots, so probes collide and wrap.
   task automatic run_phase();
      logic [oaht_pkg::KEY_W-1:0]  pool_key [POOL_KEYS];
      logic [oaht_pkg::HASH_W-1:0] pool_hash [POOL_KEYS];
      logic [5:0]                  base;
      logic [oaht_pkg::CMD_W-1:0]  cmd;
      logic [oaht_pkg::KEY_W-1:0]  key;
      logic [oaht_pkg::HASH_W-1:0] key_hash;
      int                          roll;
      int                          pick;
      base = 6'($urandom_range(63));
      foreach (pool_key[i]) begin
         pool_key[i] = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
         pool_hash[i] = $urandom;
         pool_hash[i][5:0] = 6'(base + 6'($urandom_range(7)));
      end
      repeat (PHASE_REQUESTS) begin
         roll = $urandom_range(99);
         pick = $urandom_range(POOL_KEYS - 1);
         key = pool_key[pick];
         key_hash = pool_hash[pick];
         if (roll < 45) begin
            cmd = oaht_pkg::CMD_SET;
         end else if (roll < 75) begin
            cmd = oaht_pkg::CMD_GET;
         end else if (roll < 95) begin
            cmd = oaht_pkg::CMD_DEL;
         end else if (roll < 97) begin
            cmd = CMD_UNUSED;
         end else begin
            cmd = oaht_pkg::CMD_W'($urandom_range(3));
            key = $urandom;
            key_hash = $urandom;
         end
         send_request(cmd, key, key_hash, {$urandom, $urandom});
      end
   endtask

   initial begin
      int p;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A zero limit refuses every insert that needs an empty slot.
      write_limit(6'd0);
      send_request(oaht_pkg::CMD_SET, 32'h0000_1234, 32'h0000_0005, 64'h0123_4567_89AB_CDEF);
      send_request(oaht_pkg::CMD_GET, 32'h0000_1234, 32'h0000_0005, '0);
      wait_idle();

      write_limit(6'd1);
      send_request(oaht_pkg::CMD_SET, 32'h0000_1234, 32'h0000_0005, 64'h0123_4567_89AB_CDEF);
      send_request(oaht_pkg::CMD_SET, 32'hABCD_0001, 32'h8000_0045, 64'h1111_2222_3333_4444);
      send_request(oaht_pkg::CMD_SET, 32'h0000_1234, 32'h0000_0005, 64'hFEDC_BA98_7654_3210);
      send_request(oaht_pkg::CMD_GET, 32'h0000_1234, 32'h0000_0005, '0);
      send_request(oaht_pkg::CMD_DEL, 32'h0000_1234, 32'h0000_0005, '1);
      send_request(oaht_pkg::CMD_SET, 32'hABCD_0001, 32'h8000_0045, 64'h1111_2222_3333_4444);
      send_request(oaht_pkg::CMD_GET, 32'hABCD_0001, 32'h8000_0045, '0);
      wait_idle();

      // Slot at the top of the table, wraparound, key zero and the unused command.
      write_limit(6'd63);
      send_request(oaht_pkg::CMD_SET, 32'h0000_0000, 32'hFFFF_FFFF, '1);
      send_request(oaht_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      send_request(oaht_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
      send_request(oaht_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF, '0);
      send_request(CMD_UNUSED, '1, '1, '1);
      send_request(oaht_pkg::CMD_DEL, 32'h0000_0000, 32'hFFFF_FFFF, '0);
      send_request(oaht_pkg::CMD_DEL, 32'h0000_0000, 32'hFFFF_FFFF, '0);
      send_request(oaht_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      send_request(oaht_pkg::CMD_DEL, 32'h5A5A_5A5A, 32'h0000_0010, '0);
      send_request(oaht_pkg::CMD_SET, 32'h0000_0000, 32'h0000_003F, 64'h8000_0000_0000_0001);
      send_request(oaht_pkg::CMD_GET, 32'hABCD_0001, 32'h0000_0020, '0);
      send_request(oaht_pkg::CMD_GET, 32'h0000_0000, 32'h0000_003F, '0);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         write_limit(PHASE_LIMIT[p]);
         case (p % 3)
            0: begin
               send_idle_pct = 6;
               rsp_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               rsp_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         if (p == 2) hold_request = HOLD_CYCLES;
         run_phase();
      end
      wait_idle();

      $display("Run covered %0d requests over %0d limit settings: %0d hits, %0d refused sets.",
               sb.requests, RANDOM_PHASES + 3, sb.hits, sb.refusals);
      $display("Idle patterns on both sides and a %0d-cycle receiver hold-off were applied.",
               HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
